[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define TLF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define TLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/tlf_pkg.sv]
`default_nettype none

package tlf_pkg;

    // default maximum fold width
    localparam int MAX_WIDTH_DEF = 32;

    // width of the fold width register
    localparam int CFG_W = 6;

    // fold width after reset
    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd20;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[rtl/tlf_if.sv]
`default_nettype none

// input byte channel
interface tlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_end;

    modport source (output valid, output in_char, output is_end, input ready);
    modport sink   (input valid, input in_char, input is_end, output ready);
endinterface

// result byte channel
interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// fold width write channel
interface tlf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tlf_pkg::CFG_W-1:0]  fold_width;

    modport source (output valid, output fold_width, input ready);
    modport sink   (input valid, input fold_width, output ready);
endinterface

`default_nettype wire

[rtl/text_line_folder_unit.sv]
// channel    | dir | payload                 | transfer when
// -----------+-----+-------------------------+---------------------------
// i_in_ch    | in  | in_char[7:0], is_end    | valid && ready
// o_out_ch   | out | out_char[7:0], last     | valid && ready
// i_cfg_ch   | in  | fold_width[5:0]         | valid (ready held high)
//
// an input byte that causes no output leaves the unit idle; one that causes
// k output bytes starts an emit phase that refuses input and reads each byte
// from the single-port line memory, which streams out at one byte per cycle while the output is not stalled.
// reset is synchronous: the line is emptied and the fold width goes to 20.
// a stall on the output holds the memory read register and the output
// register; the sequencer waits and nothing is lost.
`default_nettype none

module text_line_folder_unit #(
    parameter int MAX_WIDTH = tlf_pkg::MAX_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tlf_in_if.sink      i_in_ch,
    tlf_out_if.source   o_out_ch,
    tlf_cfg_if.sink     i_cfg_ch
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // circular index: base plus offset, wrapped at the memory depth
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(off);
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // line memory and its read register
    logic [7:0]                 r_line_mem [DEPTH];
    logic [7:0]                 r_rd_data;

    // line state
    logic [tlf_pkg::CFG_W-1:0]  r_fold_width;
    logic [AW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_fill, n_fill;
    logic [CW-1:0]              r_blank_idx, n_blank_idx;
    logic                       r_blank_seen, n_blank_seen;

    // emit sequencer
    tlf_pkg::t_state            r_state, n_state;
    logic [AW-1:0]              r_rd_ptr;
    logic [CW-1:0]              r_rem;
    logic                       r_nl_left;

    // read in flight and output register
    logic                       r_pend, r_pend_nl, r_pend_last;
    logic                       r_out_valid, r_out_last;
    logic [7:0]                 r_out_char;

    logic [CW-1:0]              w_eff;
    logic                       in_acc, is_nl, is_blank, can_store, wr_en;
    logic [AW-1:0]              wr_addr;
    logic [CW-1:0]              fill1, drop, emit_cnt;
    logic                       emit_nl, fold;
    logic                       out_free, issue, rd_en, last_issue, load_out;

    // effective width, clamped to 1..MAX_WIDTH
    always_comb begin
        if (r_fold_width == '0) begin
            w_eff = CW'(1);
        end else if (r_fold_width > tlf_pkg::CFG_W'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_fold_width);
        end
    end

    // outputs of the sequencer
    always_comb begin
        i_in_ch.ready = (r_state == tlf_pkg::ST_IDLE);
        out_free      = !r_out_valid || o_out_ch.ready;
        issue         = (r_state == tlf_pkg::ST_EMIT) && (!r_pend || out_free);
        rd_en         = issue && (r_rem != '0);
        last_issue    = (r_rem == '0) || ((r_rem == CW'(1)) && !r_nl_left);
        load_out      = r_pend && out_free;
    end

    assign in_acc = i_in_ch.valid && i_in_ch.ready;

    // line update for an accepted byte
    always_comb begin
        is_nl     = i_in_ch.is_end || (i_in_ch.in_char == tlf_pkg::CH_NEWLINE);
        is_blank  = (i_in_ch.in_char == tlf_pkg::CH_SPACE) ||
                    (i_in_ch.in_char == tlf_pkg::CH_TAB);
        can_store = (r_fill < CW'(DEPTH));
        wr_en     = in_acc && !is_nl && can_store;
        wr_addr   = f_wrap(r_head, r_fill);
        fill1     = can_store ? (r_fill + CW'(1)) : r_fill;

        n_head       = r_head;
        n_fill       = r_fill;
        n_blank_idx  = r_blank_idx;
        n_blank_seen = r_blank_seen;
        emit_cnt     = '0;
        emit_nl      = 1'b0;
        drop         = '0;
        fold         = 1'b0;

        if (is_nl) begin
            // flush the whole line, newline only when something was stored
            emit_cnt     = r_fill;
            emit_nl      = (r_fill != '0);
            n_fill       = '0;
            n_blank_idx  = '0;
            n_blank_seen = 1'b0;
        end else begin
            n_fill = fill1;
            if (can_store && is_blank) begin
                n_blank_idx  = r_fill;
                n_blank_seen = 1'b1;
            end
            fold = (fill1 > w_eff);
            if (fold) begin
                if (n_blank_seen) begin
                    // break at the last blank and drop it
                    emit_cnt = n_blank_idx;
                    emit_nl  = (n_blank_idx != '0);
                    drop     = n_blank_idx + CW'(1);
                end else begin
                    // hard break at the width
                    emit_cnt = w_eff;
                    emit_nl  = 1'b1;
                    drop     = w_eff;
                end
                n_fill       = fill1 - drop;
                n_head       = f_wrap(r_head, drop);
                n_blank_idx  = '0;
                n_blank_seen = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlf_pkg::ST_IDLE: begin
                if (in_acc && ((emit_cnt != '0) || emit_nl)) begin
                    n_state = tlf_pkg::ST_EMIT;
                end
            end
            tlf_pkg::ST_EMIT: begin
                if (issue && last_issue) begin
                    n_state = tlf_pkg::ST_IDLE;
                end
            end
            default: n_state = tlf_pkg::ST_IDLE;
        endcase
    end

    // line memory: write on store, registered read during emit
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[wr_addr] <= i_in_ch.in_char;
        end
        if (rd_en) begin
            r_rd_data <= r_line_mem[r_rd_ptr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tlf_pkg::ST_IDLE;
            r_fold_width <= tlf_pkg::WIDTH_RESET;
            r_head       <= '0;
            r_fill       <= '0;
            r_blank_idx  <= '0;
            r_blank_seen <= 1'b0;
            r_rem        <= '0;
            r_nl_left    <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // fold width write
            if (i_cfg_ch.valid) begin
                r_fold_width <= i_cfg_ch.fold_width;
            end

            // line state and emit setup on an input transfer
            if (in_acc) begin
                r_head       <= n_head;
                r_fill       <= n_fill;
                r_blank_idx  <= n_blank_idx;
                r_blank_seen <= n_blank_seen;
                r_rem        <= emit_cnt;
                r_nl_left    <= emit_nl;
            end else if (issue) begin
                if (r_rem != '0) begin
                    r_rem <= r_rem - CW'(1);
                end else begin
                    r_nl_left <= 1'b0;
                end
            end

            // one item in flight between memory and output register
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // emit payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_ptr <= r_head;
        end else if (rd_en) begin
            r_rd_ptr <= f_wrap(r_rd_ptr, CW'(1));
        end
        if (issue) begin
            r_pend_nl   <= (r_rem == '0);
            r_pend_last <= last_issue;
        end
        if (load_out) begin
            r_out_char <= r_pend_nl ? tlf_pkg::CH_NEWLINE : r_rd_data;
            r_out_last <= r_pend_last;
        end
    end

    assign i_cfg_ch.ready    = 1'b1;
    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.out_char = r_out_char;
    assign o_out_ch.last     = r_out_last;

endmodule

`default_nettype wire

[rtl/tlf_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module tlf_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_char,
    input wire       i_out_last,
    input wire       i_cfg_valid,
    input wire       i_cfg_ready
);

    // a stalled result holds its payload
    `TLF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) && $stable(i_out_last), "stalled result changed")

    // the closing byte of every burst is a newline
    `TLF_ASSERT(a_last_nl, i_clk, i_rst_n, i_out_valid && i_out_last |-> i_out_char == tlf_pkg::CH_NEWLINE, "last byte is not a newline")

    // reset leaves no result pending
    `TLF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // width writes are never refused
    `TLF_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid |-> i_cfg_ready, "width write stalled")

endmodule

bind text_line_folder_unit tlf_checker u_tlf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_char  (o_out_ch.out_char),
    .i_out_last  (o_out_ch.last),
    .i_cfg_valid (i_cfg_ch.valid),
    .i_cfg_ready (i_cfg_ch.ready)
);

`default_nettype wire
